/* design/utf8_to_font_code_decoder_unit_assert.svh */
// ---------------------------------------------------------------------------
// utf8_to_font_code_decoder_unit_assert.svh
// Assertion macros used by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_FONT_CODE_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_FONT_CODE_DECODER_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define UFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define UFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/utf8fc_pkg.sv */
// ---------------------------------------------------------------------------
// utf8fc_pkg
// Types, constants and the codepoint-to-font map of the UTF-8 decoder.
// ---------------------------------------------------------------------------
package utf8fc_pkg;

    localparam int unsigned QDepth = 3;

    localparam logic [7:0] CodeUnknown = 8'h3F;
    localparam logic [7:0] CodeEnd     = 8'h00;

    // One result transaction.
    typedef struct packed {
        logic [7:0] font_code;
        logic       cell_valid;
        logic       string_end;
        logic       last_of_item;
    } t_result;

    // Decoder output toward the result queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

    // Map a decoded codepoint to its font position.
    function automatic logic [7:0] map_point(input logic [15:0] cp);
        logic [15:0] diff;
        logic [7:0]  code;
        begin
            code = CodeUnknown;
            diff = 16'h0000;
            if (cp >= 16'h0020 && cp <= 16'h007E) begin
                code = cp[7:0];
            end else if (cp >= 16'h0410 && cp <= 16'h042F) begin
                diff = cp - 16'h0410;
                code = 8'h80 + diff[7:0];
            end else if (cp >= 16'h0430 && cp <= 16'h044F) begin
                diff = cp - 16'h0430;
                code = 8'hA0 + diff[7:0];
            end else begin
                case (cp)
                    16'h0404: code = 8'hC0;
                    16'h0454: code = 8'hC1;
                    16'h0407: code = 8'hC2;
                    16'h0457: code = 8'hC3;
                    16'h0406: code = 8'hC4;
                    16'h0456: code = 8'hC5;
                    16'h0490: code = 8'hC6;
                    16'h0491: code = 8'hC7;
                    16'h00B0: code = 8'hC8;
                    default:  code = CodeUnknown;
                endcase
            end
            return code;
        end
    endfunction

endpackage

/* design/utf8_to_font_code_decoder_unit.sv */
// ---------------------------------------------------------------------------
// utf8_to_font_code_decoder_unit
// UTF-8 byte stream to font code stream decoder.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis takes one raw UTF-8 byte per transaction in tdata.
//   Master channel m_axis gives one result per transaction: font code in
//   tdata, tuser = {last_of_item, cell_valid}, tlast = string_end.
//   A byte gives zero, one or two results; a zero byte closes the string.
//   Path: a byte is held in the input register, decoded once the result
//   queue has room for two results, and its results are written into it.
//   Throughput: one byte per cycle while the receiver takes every result
//   and each byte gives at most one result; a byte with two results can
//   hold off the next byte while the single result port drains the
//   three-entry result queue.
//   Reset clears the sequence state, the input register and the queue.
//   When the receiver stalls, the queue fills and s_axis_tready drops once
//   two or more results are waiting and a byte is held; nothing is lost.
// ---------------------------------------------------------------------------
module utf8_to_font_code_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] font_code
    output logic [1:0] m_axis_tuser,   // [0] cell_valid, [1] last_of_item
    output logic       m_axis_tlast    // string_end
);
    import utf8fc_pkg::*;

    localparam int unsigned CntW = $clog2(QDepth + 1);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    t_result         r_q [QDepth];
    t_result         n_q [QDepth];
    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] cnt_pop;
    logic            fire;
    logic            pop;
    t_dec_out        dec;

    // Decode only when the queue has room for two results.
    assign fire          = r_in_valid && (r_count <= CntW'(1));
    assign s_axis_tready = !r_in_valid || fire;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Hold the input byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    utf8fc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_dec   (dec)
    );

    // Drop the head on a pop, then append new results.
    always_comb begin
        cnt_pop = r_count - (pop ? CntW'(1) : CntW'(0));
        for (int i = 0; i < QDepth; i++) begin
            if (pop && (i < QDepth - 1)) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (fire && dec.count != 2'd0 && CntW'(i) == cnt_pop) begin
                n_q[i] = dec.res0;
            end
            if (fire && dec.count == 2'd2 && CntW'(i) == cnt_pop + CntW'(1)) begin
                n_q[i] = dec.res1;
            end
        end
        n_count = cnt_pop + (fire ? CntW'(dec.count) : CntW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDepth; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // Present the queue head.
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_q[0].font_code;
    assign m_axis_tuser  = {r_q[0].last_of_item, r_q[0].cell_valid};
    assign m_axis_tlast  = r_q[0].string_end;

`include "utf8_to_font_code_decoder_unit_assert.svh"

    `UFD_ASSERT_NOW(a_end_marker_empty, m_axis_tvalid && m_axis_tlast, m_axis_tdata == CodeEnd && !m_axis_tuser[0], "end marker carries a cell")
    `UFD_ASSERT_NOW(a_queue_bound, 1'b1, r_count <= CntW'(QDepth), "result queue overflow")
    `UFD_ASSERT_NEXT(a_pop_only_drains, pop && !fire, r_count == $past(r_count) - CntW'(1), "queue count not reduced by pop")

endmodule

/* design/utf8fc_decode.sv */
// ---------------------------------------------------------------------------
// utf8fc_decode
// Sequence state and per-byte decode; gives zero, one or two results.
// ---------------------------------------------------------------------------
module utf8fc_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    output utf8fc_pkg::t_dec_out  o_dec
);
    import utf8fc_pkg::*;

    logic [1:0]  r_pending, n_pending;
    logic [15:0] r_point,   n_point;
    logic        r_discard, n_discard;

    logic        lead_has;
    t_result     lead_res;
    logic [1:0]  lead_pending;
    logic [15:0] lead_point;
    logic [15:0] cont_point;
    t_dec_out    dec;

    // Handle the byte as a lead byte.
    always_comb begin
        lead_has     = 1'b1;
        lead_res     = '{font_code: CodeUnknown, cell_valid: 1'b1,
                         string_end: 1'b0, last_of_item: 1'b0};
        lead_pending = 2'd0;
        lead_point   = 16'h0000;
        if (i_byte == 8'h00) begin
            lead_res = '{font_code: CodeEnd, cell_valid: 1'b0,
                         string_end: 1'b1, last_of_item: 1'b0};
        end else if (i_byte[7] == 1'b0) begin
            lead_res.font_code = map_point({8'h00, i_byte});
        end else if ((i_byte & 8'hE0) == 8'hC0) begin
            lead_has     = 1'b0;
            lead_pending = 2'd1;
            lead_point   = {11'd0, i_byte[4:0]};
        end else if ((i_byte & 8'hF0) == 8'hE0) begin
            lead_has     = 1'b0;
            lead_pending = 2'd2;
            lead_point   = {12'd0, i_byte[3:0]};
        end
    end

    assign cont_point = {r_point[9:0], i_byte[5:0]};

    // Select results and next state.
    always_comb begin
        dec       = '0;
        n_pending = r_pending;
        n_point   = r_point;
        n_discard = r_discard;
        if (r_discard) begin
            if (i_byte == 8'h00) begin
                n_discard = 1'b0;
            end
        end else if (r_pending == 2'd0) begin
            n_pending = lead_pending;
            n_point   = lead_point;
            dec.res0  = lead_res;
            dec.count = lead_has ? 2'd1 : 2'd0;
        end else if (i_byte[7:6] == 2'b10) begin
            n_pending = r_pending - 2'd1;
            n_point   = cont_point;
            if (r_pending == 2'd1) begin
                n_point   = 16'h0000;
                dec.count = 2'd1;
                if (cont_point == 16'h0000) begin
                    n_discard = 1'b1;
                    dec.res0  = '{font_code: CodeEnd, cell_valid: 1'b0,
                                  string_end: 1'b1, last_of_item: 1'b0};
                end else begin
                    dec.res0 = '{font_code: map_point(cont_point), cell_valid: 1'b1,
                                 string_end: 1'b0, last_of_item: 1'b0};
                end
            end
        end else begin
            // broken sequence, then reprocess the byte as a lead
            n_pending = lead_pending;
            n_point   = lead_point;
            dec.res0  = '{font_code: CodeUnknown, cell_valid: 1'b1,
                          string_end: 1'b0, last_of_item: 1'b0};
            dec.res1  = lead_res;
            dec.count = lead_has ? 2'd2 : 2'd1;
        end
        // mark the final result of this byte
        if (dec.count == 2'd1) begin
            dec.res0.last_of_item = 1'b1;
        end
        if (dec.count == 2'd2) begin
            dec.res1.last_of_item = 1'b1;
        end
    end

    assign o_dec = dec;

    // Advance state on each decoded byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_point   <= 16'h0000;
            r_discard <= 1'b0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_point   <= n_point;
            r_discard <= n_discard;
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Regression bench for the UTF-8 to font code decoder.
// Drives raw UTF-8 bytes into the slave stream and checks every font code
// result against an in-bench decoder model kept in step with each accepted
// byte. Directed strings cover the code map bounds and the error paths.
// Random strings, mostly well formed with some noise mixed in, run under
// several source and sink idling mixes, a long sink stall and a full drain.
// ---------------------------------------------------------------------------
module tb_top;

    import utf8fc_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] byte_in
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] font_code
    logic [1:0] m_axis_tuser;           // [0] cell_valid, [1] last_of_item
    logic       m_axis_tlast;           // string_end

    // Decoder model state
    logic [1:0]  cont_left = 2'd0;
    logic [15:0] point_acc = 16'h0000;
    logic        dropping = 1'b0;

    t_result expected_cells[$];
    t_result byte_cells[$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned snk_hold_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned err_count = 0;

    utf8_to_font_code_decoder_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Font position of a decoded codepoint
    function automatic logic [7:0] font_of_point(input logic [15:0] cp);
        logic [15:0] off;
        logic [7:0]  code;
        off  = cp - 16'h0410;
        code = CodeUnknown;
        if (cp >= 16'h0020 && cp <= 16'h007E) begin
            code = cp[7:0];
        end else if (off < 16'd64) begin
            // capitals then small letters, one contiguous block
            code = 8'h80 + off[7:0];
        end else begin
            case (cp)
                16'h0404: code = 8'hC0;
                16'h0454: code = 8'hC1;
                16'h0407: code = 8'hC2;
                16'h0457: code = 8'hC3;
                16'h0406: code = 8'hC4;
                16'h0456: code = 8'hC5;
                16'h0490: code = 8'hC6;
                16'h0491: code = 8'hC7;
                16'h00B0: code = 8'hC8;
                default:  code = CodeUnknown;
            endcase
        end
        return code;
    endfunction

    function automatic void add_cell(input logic [7:0] code, input logic valid,
                                     input logic str_end);
        t_result r;
        r.font_code    = code;
        r.cell_valid   = valid;
        r.string_end   = str_end;
        r.last_of_item = 1'b0;
        byte_cells.push_back(r);
    endfunction

    // Byte seen with no sequence open
    function automatic void decode_lead(input logic [7:0] b);
        if (b == 8'h00) begin
            add_cell(CodeEnd, 1'b0, 1'b1);
        end else if (!b[7]) begin
            add_cell(font_of_point({8'h00, b}), 1'b1, 1'b0);
        end else if (b[7:5] == 3'b110) begin
            cont_left = 2'd1;
            point_acc = {11'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            cont_left = 2'd2;
            point_acc = {12'd0, b[3:0]};
        end else begin
            add_cell(CodeUnknown, 1'b1, 1'b0);
        end
    endfunction

    // Advance the model by one accepted byte and queue its results
    function automatic void decode_byte(input logic [7:0] b);
        t_result r;
        byte_cells.delete();
        if (dropping) begin
            if (b == 8'h00) dropping = 1'b0;
        end else if (cont_left == 2'd0) begin
            decode_lead(b);
        end else if (b[7:6] == 2'b10) begin
            point_acc = {point_acc[9:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                if (point_acc == 16'h0000) begin
                    // overlong zero closes the string and drops until 0x00
                    add_cell(CodeEnd, 1'b0, 1'b1);
                    dropping = 1'b1;
                end else begin
                    add_cell(font_of_point(point_acc), 1'b1, 1'b0);
                end
                point_acc = 16'h0000;
            end
        end else begin
            // broken sequence, then retry the byte as a lead
            cont_left = 2'd0;
            point_acc = 16'h0000;
            add_cell(CodeUnknown, 1'b1, 1'b0);
            decode_lead(b);
        end
        if (byte_cells.size() > 0) begin
            r = byte_cells.pop_back();
            r.last_of_item = 1'b1;
            byte_cells.push_back(r);
        end
        foreach (byte_cells[i]) expected_cells.push_back(byte_cells[i]);
    endfunction

    // Offer one byte, hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(b);
        bytes_sent++;
    endtask

    // Encode a codepoint as canonical UTF-8
    task automatic send_point(input logic [15:0] cp);
        if (cp < 16'h0080) begin
            send_byte(cp[7:0]);
        end else if (cp < 16'h0800) begin
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
        end else begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end
    endtask

    // Drop valid and wait until every queued result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_cells.size() != 0);
    endtask

    // Drop valid so the last byte is not taken twice, then switch the mix
    task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        @(posedge i_clk);
    endtask

    // Sink side: random ready, long hold-off on request, result check
    always @(posedge i_clk) begin : sink_proc
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected result: tdata=%h tuser=%b tlast=%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end else begin
                want = expected_cells.pop_front();
                if (m_axis_tdata !== want.font_code ||
                    m_axis_tuser[0] !== want.cell_valid ||
                    m_axis_tuser[1] !== want.last_of_item ||
                    m_axis_tlast !== want.string_end) begin
                    $display("%0t: mismatch: expected code=%h valid=%b end=%b last=%b",
                             $time, want.font_code, want.cell_valid, want.string_end,
                             want.last_of_item);
                    $display("%0t:           actual   code=%h valid=%b end=%b last=%b",
                             $time, m_axis_tdata, m_axis_tuser[0], m_axis_tlast,
                             m_axis_tuser[1]);
                    err_count++;
                end
            end
        end
        if (snk_hold_left != 0) begin
            m_axis_tready <= 1'b0;
            snk_hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Printable ASCII bounds, controls and the terminator
    task automatic test_ascii();
        send_byte(8'h20);
        send_byte(8'h7E);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h00);
    endtask

    // Cyrillic block bounds, specials and a three-byte codepoint
    task automatic test_multibyte();
        send_point(16'h0410);
        send_point(16'h044F);
        send_point(16'h0491);
        send_point(16'h00B0);
        send_point(16'hFFFF);
    endtask

    // Four-byte lead, stray continuation, broken sequences, overlong zero
    task automatic test_errors();
        send_byte(8'hF0);
        send_byte(8'h80);
        send_byte(8'hD0);
        send_byte(8'h41);
        send_byte(8'hD0);
        send_byte(8'h00);
        send_byte(8'hC0);
        send_byte(8'h80);
        send_byte(8'h41);
        send_byte(8'h00);
    endtask

    // One random character or piece of noise
    task automatic send_random_char();
        int unsigned sel;
        int unsigned n;
        logic [15:0] cp;
        logic [7:0]  b;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (sel < 55) begin
            send_point(16'($urandom_range(16'h0410, 16'h044F)));
        end else if (sel < 63) begin
            case ($urandom_range(0, 8))
                0: cp = 16'h0404;
                1: cp = 16'h0454;
                2: cp = 16'h0407;
                3: cp = 16'h0457;
                4: cp = 16'h0406;
                5: cp = 16'h0456;
                6: cp = 16'h0490;
                7: cp = 16'h0491;
                default: cp = 16'h00B0;
            endcase
            send_point(cp);
        end else if (sel < 73) begin
            send_point(16'($urandom_range(16'h0080, 16'h07FF)));
        end else if (sel < 83) begin
            send_point(16'($urandom_range(16'h0800, 16'hFFFF)));
        end else if (sel < 86) begin
            send_byte($urandom_range(0, 1) ? 8'h7F : 8'($urandom_range(1, 8'h1F)));
        end else if (sel < 89) begin
            send_byte(8'($urandom));
        end else if (sel < 92) begin
            // lead byte followed by a non-continuation byte
            send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hDF))
                                           : 8'($urandom_range(8'hE0, 8'hEF)));
            if ($urandom_range(0, 1)) send_byte(8'($urandom_range(8'hE0, 8'hEF)));
            do b = 8'($urandom); while (b[7:6] == 2'b10);
            send_byte(b);
        end else if (sel < 94) begin
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end else if (sel < 96) begin
            send_byte(8'($urandom_range(8'hF0, 8'hFF)));
        end else if (sel < 98) begin
            // overlong form, zero half the time; a zero is followed by junk until 0x00
            cp = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(1, 127));
            if ($urandom_range(0, 1)) begin
                send_byte({3'b110, 3'b000, cp[7:6]});
            end else begin
                send_byte(8'hE0);
                send_byte({2'b10, 4'b0000, cp[7:6]});
            end
            send_byte({2'b10, cp[5:0]});
            if (cp == 16'h0000) begin
                n = $urandom_range(0, 4);
                repeat (n) send_byte(8'($urandom));
                send_byte(8'h00);
            end
        end else begin
            send_byte(8'h00);
        end
    endtask

    task automatic test_random_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_char();
    endtask

    // Stall the sink while the source keeps offering, so the input backs up
    task automatic test_sink_stall();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        snk_hold_left = 200;
        @(posedge i_clk);
        test_random_traffic(40);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii();
        test_multibyte();
        test_errors();
        wait_drained();

        set_idling(26, 71);
        test_random_traffic(170);
        wait_drained();

        set_idling(71, 26);
        test_random_traffic(170);

        set_idling(0, 0);
        test_sink_stall();
        test_random_traffic(170);

        // let the last results out and the pipeline settle
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (err_count == 0 && expected_cells.size() == 0) begin
            $display("utf8_to_font_code_decoder_unit regression: pass");
        end else begin
            $display("utf8_to_font_code_decoder_unit regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("utf8_to_font_code_decoder_unit regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/utf8fc_pkg.sv
design/utf8fc_decode.sv
design/utf8_to_font_code_decoder_unit.sv
verif/tb_top.sv
